// ===== sv/cvs_pkg.sv =====
package cvs_pkg;

    // Datapath and field widths
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 31;
    localparam int COEF_W     = 25;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int Q24_FRAC   = 24;
    localparam int OUT_SHIFT  = 10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OSC1_STEP   = 3'd0,
        CFG_OSC2_STEP   = 3'd1,
        CFG_FILTER_FREQ = 3'd2,
        CFG_FILTER_DAMP = 3'd3,
        CFG_DECAY       = 3'd4
    } cfg_reg_t;

    // Command codes
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_TRIGGER = 1'b1;

    // Reset values
    localparam logic [STEP_W-1:0] OSC1_STEP_RST   = 31'd53565351;
    localparam logic [STEP_W-1:0] OSC2_STEP_RST   = 31'd79276720;
    localparam logic [COEF_W-1:0] FILTER_FREQ_RST = 25'd1629900;
    localparam logic [COEF_W-1:0] FILTER_DAMP_RST = 25'd6710886;
    localparam logic [COEF_W-1:0] DECAY_RST       = 25'd16775631;
    localparam logic [DATA_W-1:0] PHASE_TWO_RST   = 32'h4000_0000;

    // Fixed-point constants
    localparam logic [COEF_W-1:0] Q24_ONE      = 25'h100_0000;
    localparam logic [DATA_W-1:0] SQUARE_LEVEL = 32'h0080_0000;

    // Request to the shared Q24 multiplier
    typedef struct packed {
        logic                     en;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } mul_req_t;

endpackage

// ===== sv/cvs_cmd_if.sv =====
interface cvs_cmd_if;
    import cvs_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [COEF_W-1:0] velocity;

    modport source (output valid, output command, output velocity, input ready);
    modport sink (input valid, input command, input velocity, output ready);

endinterface

// ===== sv/cvs_sample_if.sv =====
interface cvs_sample_if;
    import cvs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);

endinterface

// ===== sv/cvs_cfg_if.sv =====
interface cvs_cfg_if;
    import cvs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

// ===== sv/cvs_mul.sv =====
module cvs_mul (
    input  logic                            clk,
    input  cvs_pkg::mul_req_t               req,
    output logic [cvs_pkg::DATA_W-1:0]      q24
);
    import cvs_pkg::*;

    logic signed [2*DATA_W-1:0] full;
    logic [DATA_W-1:0]          prod_reg;

    // Full signed product; floor by 2^24 is the slice above the fraction
    assign full = req.a * req.b;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= full[Q24_FRAC+DATA_W-1:Q24_FRAC];
        end
    end

    assign q24 = prod_reg;

endmodule

// ===== sv/cowbell_voice_synth_core.sv =====
// Channel  | Dir | Payload                       | Handshake
// ---------+-----+-------------------------------+------------------
// cmd      | in  | command, velocity[24:0]       | valid / ready
// result   | out | sample[15:0] signed           | valid / ready
// cfg      | in  | index[2:0], data[30:0]        | valid / ready
//
// A tick request runs through the accept cycle plus 8 sequencer steps, making
// six passes through the one shared 32x32 Q24 multiplier (registered output).
// A trigger request is taken in its accept cycle and gives no result.
// cfg is always ready; writes are registered on acceptance.
// rst_n is asynchronous, active low; control, config and voice state return to defaults at once.
// A finished sample waits in the output register; cmd stays ready meanwhile,
// and the last step holds only if the previous sample is still not taken.
module cowbell_voice_synth_core (
    input  logic         clk,
    input  logic         rst_n,
    cvs_cmd_if.sink      cmd,
    cvs_sample_if.source result,
    cvs_cfg_if.sink      cfg
);
    import cvs_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_S1   = 9'b000000010,
        ST_S2   = 9'b000000100,
        ST_S3   = 9'b000001000,
        ST_S4   = 9'b000010000,
        ST_S5   = 9'b000100000,
        ST_S6   = 9'b001000000,
        ST_S7   = 9'b010000000,
        ST_S8   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0] osc1_step_reg, osc2_step_reg;
    logic [COEF_W-1:0] filter_freq_reg, filter_damp_reg, decay_reg;
    logic [DATA_W-1:0] phase_one_reg, phase_two_reg;
    logic [DATA_W-1:0] band_low_reg, band_pass_reg, envelope_reg;
    logic [COEF_W-1:0] hit_level_reg;
    logic [DATA_W-1:0] mix_reg, high_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic              res_valid_reg, res_valid_next;

    logic [DATA_W-1:0]   phase_one_sum, phase_two_sum, mix_val, high_val, mul_q;
    logic [SAMPLE_W-1:0] sat_val;
    logic                cmd_take, cfg_take, out_free;
    mul_req_t            mul_req;

    assign cmd.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign cmd_take      = cmd.valid && cmd.ready;
    assign cfg_take      = cfg.valid && cfg.ready;
    assign result.valid  = res_valid_reg;
    assign result.sample = sample_reg;
    assign out_free      = !res_valid_reg || result.ready;

    // Oscillators and the averaged square pair
    assign phase_one_sum = phase_one_reg + {1'b0, osc1_step_reg};
    assign phase_two_sum = phase_two_reg + {1'b0, osc2_step_reg};

    always_comb
    begin
        if (phase_one_sum[DATA_W-1] != phase_two_sum[DATA_W-1])
        begin
            mix_val = '0;
        end
        else if (phase_one_sum[DATA_W-1])
        begin
            mix_val = -SQUARE_LEVEL;
        end
        else
        begin
            mix_val = SQUARE_LEVEL;
        end
    end

    // High-pass term: mix less low band less damped band
    assign high_val = mix_reg - band_low_reg - mul_q;

    // Output: drop 10 fraction bits, clamp to 16 bits
    always_comb
    begin
        if (mul_q[DATA_W-1:OUT_SHIFT+SAMPLE_W-1] ==
            {(DATA_W-OUT_SHIFT-SAMPLE_W+1){mul_q[OUT_SHIFT+SAMPLE_W-1]}})
        begin
            sat_val = mul_q[OUT_SHIFT+SAMPLE_W-1:OUT_SHIFT];
        end
        else if (mul_q[DATA_W-1])
        begin
            sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            ST_S1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({{(DATA_W-COEF_W){1'b0}}, filter_freq_reg});
                mul_req.b  = $signed(band_pass_reg);
            end
            ST_S2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({{(DATA_W-COEF_W){1'b0}}, filter_damp_reg});
                mul_req.b  = $signed(band_pass_reg);
            end
            ST_S4:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({{(DATA_W-COEF_W){1'b0}}, filter_freq_reg});
                mul_req.b  = $signed(high_reg);
            end
            ST_S5:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed(envelope_reg);
                mul_req.b  = $signed({{(DATA_W-COEF_W){1'b0}}, decay_reg});
            end
            ST_S6:
            begin
                // envelope_reg still holds the undecayed value this cycle
                mul_req.en = 1'b1;
                mul_req.a  = $signed(band_pass_reg);
                mul_req.b  = $signed(envelope_reg);
            end
            ST_S7:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed(mul_q);
                mul_req.b  = $signed({{(DATA_W-COEF_W){1'b0}}, hit_level_reg});
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    cvs_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .q24 (mul_q)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take && (cmd.command == CMD_TICK))
                begin
                    state_next = ST_S1;
                end
            end
            ST_S1: state_next = ST_S2;
            ST_S2: state_next = ST_S3;
            ST_S3: state_next = ST_S4;
            ST_S4: state_next = ST_S5;
            ST_S5: state_next = ST_S6;
            ST_S6: state_next = ST_S7;
            ST_S7: state_next = ST_S8;
            ST_S8:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if ((state_reg == ST_S8) && out_free)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control, configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            res_valid_reg   <= 1'b0;
            osc1_step_reg   <= OSC1_STEP_RST;
            osc2_step_reg   <= OSC2_STEP_RST;
            filter_freq_reg <= FILTER_FREQ_RST;
            filter_damp_reg <= FILTER_DAMP_RST;
            decay_reg       <= DECAY_RST;
            phase_one_reg   <= '0;
            phase_two_reg   <= PHASE_TWO_RST;
            band_low_reg    <= '0;
            band_pass_reg   <= '0;
            envelope_reg    <= '0;
            hit_level_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;

            if (cfg_take)
            begin
                case (cfg.index)
                    CFG_OSC1_STEP:   osc1_step_reg   <= cfg.data[STEP_W-1:0];
                    CFG_OSC2_STEP:   osc2_step_reg   <= cfg.data[STEP_W-1:0];
                    CFG_FILTER_FREQ: filter_freq_reg <= cfg.data[COEF_W-1:0];
                    CFG_FILTER_DAMP: filter_damp_reg <= cfg.data[COEF_W-1:0];
                    CFG_DECAY:
                    begin
                        decay_reg <= (cfg.data[COEF_W-1:0] > Q24_ONE) ?
                                     Q24_ONE : cfg.data[COEF_W-1:0];
                    end
                    default: ;
                endcase
            end

            // Trigger: latch velocity (clamped to one), envelope to one
            if (cmd_take && (cmd.command == CMD_TRIGGER))
            begin
                hit_level_reg <= (cmd.velocity > Q24_ONE) ? Q24_ONE : cmd.velocity;
                envelope_reg  <= {{(DATA_W-COEF_W){1'b0}}, Q24_ONE};
            end

            if (state_reg == ST_S1)
            begin
                phase_one_reg <= phase_one_sum;
                phase_two_reg <= phase_two_sum;
            end

            if (state_reg == ST_S2)
            begin
                band_low_reg <= band_low_reg + mul_q;
            end

            if (state_reg == ST_S5)
            begin
                band_pass_reg <= band_pass_reg + mul_q;
            end

            if (state_reg == ST_S6)
            begin
                envelope_reg <= mul_q;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_S1)
        begin
            mix_reg <= mix_val;
        end
        if (state_reg == ST_S3)
        begin
            high_reg <= high_val;
        end
        if ((state_reg == ST_S8) && out_free)
        begin
            sample_reg <= sat_val;
        end
    end

endmodule

// ===== sv/cvs_checker.sv =====
module cvs_checker (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic cmd_command,
    input logic res_valid,
    input logic res_ready,
    input logic cfg_ready
);
    import cvs_pkg::*;

    // A tick request makes the block busy in the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && (cmd_command == CMD_TICK)) |=> !cmd_ready)
        else $error("cmd still ready after a tick request");

    // A trigger request never produces a sample
    a_trigger_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && (cmd_command == CMD_TRIGGER) && !res_valid)
        |=> !res_valid)
        else $error("sample appeared after a trigger request");

    // A new sample only comes out of a busy period
    a_sample_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("sample appeared while idle");

    // A waiting sample is held until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("sample dropped before it was taken");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg not ready");

endmodule

bind cowbell_voice_synth_core cvs_checker u_cvs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_command (cmd.command),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .cfg_ready   (cfg.ready)
);
